[rtl/rau_pkg.sv]
// Shared types and constants for the rational arithmetic unit.
package rau_pkg;

  // Default operand width and the fixed width of each result part
  localparam int unsigned OperandWidthDef = 16;
  localparam int unsigned ResWidth        = 33;
  localparam int unsigned CmdWidth        = 4;

  // Operation codes carried on the input tuser
  typedef enum logic [CmdWidth-1:0] {
    CMD_ADD    = 4'd0,
    CMD_SUB    = 4'd1,
    CMD_MUL    = 4'd2,
    CMD_DIV    = 4'd3,
    CMD_LT     = 4'd4,
    CMD_LE     = 4'd5,
    CMD_GT     = 4'd6,
    CMD_GE     = 4'd7,
    CMD_EQ     = 4'd8,
    CMD_NE     = 4'd9,
    CMD_REDUCE = 4'd10
  } rau_cmd_e;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_COMB,
    ST_GCD,
    ST_DIVN,
    ST_DIVD,
    ST_OUT
  } rau_state_e;

endpackage

[rtl/rau_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
module rau_div #(
  parameter int unsigned WIDTH = 33
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] dividend_i,
  input  logic [WIDTH-1:0] divisor_i,
  output logic             done_o,
  output logic [WIDTH-1:0] quot_o
);

  localparam int unsigned CntW = $clog2(WIDTH + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [WIDTH-1:0] rem_q, rem_d;
  logic [WIDTH-1:0] quo_q, quo_d;
  logic [WIDTH-1:0] dsr_q, dsr_d;
  logic [WIDTH:0]   rem_sh;
  logic [WIDTH:0]   rem_sub;
  logic             fits;

  // One shift, compare and subtract step
  always_comb begin
    rem_sh  = {rem_q, quo_q[WIDTH-1]};
    fits    = rem_sh >= {1'b0, dsr_q};
    rem_sub = rem_sh - {1'b0, dsr_q};
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    dsr_d   = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(WIDTH);
      rem_d  = '0;
      quo_d  = dividend_i;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? rem_sub[WIDTH-1:0] : rem_sh[WIDTH-1:0];
      quo_d = {quo_q[WIDTH-2:0], fits};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider flags done while still busy");
  a_cnt_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !start_i) |-> (cnt_q != '0))
    else $error("divider busy with an empty bit count");
  a_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && dsr_q != '0) |-> (rem_q < dsr_q))
    else $error("divider partial remainder not below divisor");

endmodule

[rtl/rau_gcd.sv]
// Binary gcd unit, one shift or subtract step per cycle.
module rau_gcd #(
  parameter int unsigned WIDTH = 33
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] a_i,
  input  logic [WIDTH-1:0] b_i,
  output logic             done_o,
  output logic [WIDTH-1:0] g_o
);

  localparam int unsigned KW = $clog2(WIDTH);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [KW-1:0]    k_q, k_d;
  logic [WIDTH-1:0] a_q, a_d;
  logic [WIDTH-1:0] b_q, b_d;
  logic [WIDTH-1:0] g_q, g_d;

  // Stein step; b is never zero, so a reaching zero ends the run
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    k_d    = k_q;
    a_d    = a_q;
    b_d    = b_q;
    g_d    = g_q;
    if (start_i) begin
      busy_d = 1'b1;
      k_d    = '0;
      a_d    = a_i;
      b_d    = b_i;
    end else if (busy_q) begin
      priority if (a_q == '0) begin
        g_d    = b_q << k_q;
        busy_d = 1'b0;
        done_d = 1'b1;
      end else if (!a_q[0] && !b_q[0]) begin
        a_d = a_q >> 1;
        b_d = b_q >> 1;
        k_d = k_q + KW'(1);
      end else if (!a_q[0]) begin
        a_d = a_q >> 1;
      end else if (!b_q[0]) begin
        b_d = b_q >> 1;
      end else if (a_q >= b_q) begin
        a_d = a_q - b_q;
      end else begin
        b_d = b_q - a_q;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      k_q    <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      k_q    <= k_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    g_q <= g_d;
  end

  assign done_o = done_q;
  assign g_o    = g_q;

  a_b_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (b_q != '0))
    else $error("gcd second operand reached zero");
  a_g_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (g_q != '0))
    else $error("gcd result is zero");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("gcd flags done while still busy");

endmodule

[rtl/rational_arithmetic_unit_top.sv]
// Top level of the rational arithmetic unit: sequencer, shared multiplier, output register.
//
// Input stream: one word per operation. s_axis_tuser carries the operation code,
// s_axis_tdata the four operands (two signed fractions). Output stream: one word
// per input word, holding the reduced numerator and denominator and the
// comparison flag; m_axis_tuser flags a zero result denominator.
// An item is taken when s_axis_tvalid and s_axis_tready are both high; the unit
// then lowers s_axis_tready until the result has gone to the output register.
// Sequence: the multiplier states ST_MUL0, ST_MUL1 and ST_MUL2 (one shared
// OPERAND_WIDTH square multiplier), the combine state, then for arithmetic and
// reduce the binary gcd (one step a cycle; every shift drops a bit and each
// subtract is followed by a shift) and two quotients from the shared divider,
// then the pending result and output registers. Comparisons, errors and unused
// codes skip the gcd and the divider.
// Reset clears the sequencer and the output valid; no result is lost or made up.
// If the receiver stalls, the finished word waits in the output register and the
// next input word is taken and worked on meanwhile, finishing only once the
// register has been emptied.
module rational_arithmetic_unit_top #(
  parameter int unsigned OPERAND_WIDTH = rau_pkg::OperandWidthDef
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  // tdata fields from bit 0: lhs_num, lhs_den, rhs_num, rhs_den, zero pad
  input  logic [((4*OPERAND_WIDTH+7)/8)*8-1:0]         s_axis_tdata,
  // tuser fields from bit 0: cmd
  input  logic [rau_pkg::CmdWidth-1:0]                 s_axis_tuser,
  input  logic                                         s_axis_tvalid,
  output logic                                         s_axis_tready,
  // tdata fields from bit 0: res_num, res_den, cmp_true, zero pad
  output logic [((2*rau_pkg::ResWidth+1+7)/8)*8-1:0]   m_axis_tdata,
  // tuser fields from bit 0: div_zero
  output logic                                         m_axis_tuser,
  output logic                                         m_axis_tvalid,
  input  logic                                         m_axis_tready
);

  import rau_pkg::*;

  localparam int unsigned W    = OPERAND_WIDTH;
  localparam int unsigned PW   = 2 * W;
  localparam int unsigned MW   = 2 * W + 1;
  localparam int unsigned RW   = (MW > ResWidth) ? MW : ResWidth;
  localparam int unsigned OutW = ((2 * ResWidth + 1 + 7) / 8) * 8;

  rau_state_e state_q, state_d;

  // Captured operands
  logic [CmdWidth-1:0] cmd_q;
  logic [W-1:0]        ln_q, ld_q, rn_q, rd_q;
  rau_cmd_e            cmd;

  // Products as sign and magnitude
  logic [PW-1:0] p0_mag_q, p1_mag_q, p2_mag_q;
  logic          p0_neg_q, p1_neg_q, p2_neg_q;

  // Numerator before reduction and first quotient
  logic [MW-1:0] n_mag_q, n_mag_d;
  logic          n_neg_q, n_neg_d;
  logic [MW-1:0] qn_q;

  // Pending result
  logic [ResWidth-1:0] r_num_q, r_num_d, r_den_q, r_den_d;
  logic                r_cmp_q, r_cmp_d, r_dz_q, r_dz_d;

  // Output register
  logic                m_valid_q, m_valid_d;
  logic [ResWidth-1:0] o_num_q, o_den_q;
  logic                o_cmp_q, o_dz_q;

  // Multiplier
  logic [W-1:0]  ma, mb;
  logic          sa, sb;
  logic [PW-1:0] prod;
  logic          prod_neg;

  // Combine step
  logic [MW-1:0]        a_mag, t_mag, d_mag, sum_mag;
  logic                 t_neg, sum_neg;
  logic signed [MW-1:0] ca, cb;
  logic                 flag;

  // Sequencer outputs
  logic in_acc, ld_p0, ld_p1, ld_p2, ld_n, ld_qn, ld_res, ld_out;
  logic gcd_start, gcd_done, div_start, div_done;
  logic [MW-1:0] gcd_g, div_num, div_quot;

  function automatic logic [W-1:0] mag_of(input logic [W-1:0] x);
    return x[W-1] ? (~x + W'(1)) : x;
  endfunction

  // Signed low ResWidth bits of a sign and magnitude pair
  function automatic logic [ResWidth-1:0] wrap(input logic neg, input logic [MW-1:0] m);
    logic [RW-1:0] e;
    e = RW'(m);
    if (neg) e = RW'(0) - e;
    return e[ResWidth-1:0];
  endfunction

  assign cmd    = rau_cmd_e'(cmd_q);
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // Operand selection for the shared multiplier
  always_comb begin
    ma = mag_of(ld_q);
    sa = ld_q[W-1];
    mb = mag_of(rn_q);
    sb = rn_q[W-1];
    unique case (state_q)
      ST_MUL0: begin
        ma = mag_of(ln_q);
        sa = ln_q[W-1];
        if (cmd == CMD_REDUCE) begin
          mb = W'(1);
          sb = 1'b0;
        end else if (cmd == CMD_MUL) begin
          mb = mag_of(rn_q);
          sb = rn_q[W-1];
        end else begin
          mb = mag_of(rd_q);
          sb = rd_q[W-1];
        end
      end
      ST_MUL2: begin
        if (cmd == CMD_REDUCE) begin
          mb = W'(1);
          sb = 1'b0;
        end else if (cmd == CMD_DIV) begin
          mb = mag_of(rn_q);
          sb = rn_q[W-1];
        end else begin
          mb = mag_of(rd_q);
          sb = rd_q[W-1];
        end
      end
      default: begin
      end
    endcase
  end

  assign prod     = PW'(ma) * PW'(mb);
  assign prod_neg = (prod != '0) && (sa ^ sb);

  // Cross-product sum, difference and compare values
  always_comb begin
    a_mag = MW'(p0_mag_q);
    t_mag = MW'(p1_mag_q);
    d_mag = MW'(p2_mag_q);
    t_neg = p1_neg_q;
    if (cmd == CMD_SUB && p1_mag_q != '0) t_neg = !p1_neg_q;
    if (p0_neg_q == t_neg) begin
      sum_mag = a_mag + t_mag;
      sum_neg = p0_neg_q;
    end else if (a_mag >= t_mag) begin
      sum_mag = a_mag - t_mag;
      sum_neg = p0_neg_q;
    end else begin
      sum_mag = t_mag - a_mag;
      sum_neg = t_neg;
    end
    if (sum_mag == '0) sum_neg = 1'b0;
    ca = p0_neg_q ? (MW'(0) - a_mag) : a_mag;
    cb = p1_neg_q ? (MW'(0) - t_mag) : t_mag;
    unique case (cmd)
      CMD_LT:  flag = ca <  cb;
      CMD_LE:  flag = ca <= cb;
      CMD_GT:  flag = ca >  cb;
      CMD_GE:  flag = ca >= cb;
      CMD_EQ:  flag = ca == cb;
      default: flag = ca != cb;
    endcase
  end

  // Sequencer
  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    ld_p0         = 1'b0;
    ld_p1         = 1'b0;
    ld_p2         = 1'b0;
    ld_n          = 1'b0;
    ld_qn         = 1'b0;
    ld_res        = 1'b0;
    ld_out        = 1'b0;
    gcd_start     = 1'b0;
    div_start     = 1'b0;
    div_num       = d_mag;
    n_mag_d       = sum_mag;
    n_neg_d       = sum_neg;
    r_num_d       = '0;
    r_den_d       = '0;
    r_cmp_d       = 1'b0;
    r_dz_d        = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) state_d = ST_MUL0;
      end
      ST_MUL0: begin
        ld_p0   = 1'b1;
        state_d = ST_MUL1;
      end
      ST_MUL1: begin
        ld_p1   = 1'b1;
        state_d = ST_MUL2;
      end
      ST_MUL2: begin
        ld_p2   = 1'b1;
        state_d = ST_COMB;
      end
      ST_COMB: begin
        unique case (cmd)
          CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_REDUCE: begin
            if (cmd != CMD_ADD && cmd != CMD_SUB) begin
              n_mag_d = a_mag;
              n_neg_d = p0_neg_q;
            end
            if (p2_mag_q == '0) begin
              ld_res  = 1'b1;
              r_dz_d  = 1'b1;
              state_d = ST_OUT;
            end else begin
              ld_n      = 1'b1;
              gcd_start = 1'b1;
              state_d   = ST_GCD;
            end
          end
          CMD_LT, CMD_LE, CMD_GT, CMD_GE, CMD_EQ, CMD_NE: begin
            ld_res  = 1'b1;
            r_cmp_d = flag;
            state_d = ST_OUT;
          end
          default: begin
            ld_res  = 1'b1;
            state_d = ST_OUT;
          end
        endcase
      end
      ST_GCD: begin
        div_num = n_mag_q;
        if (gcd_done) begin
          div_start = 1'b1;
          state_d   = ST_DIVN;
        end
      end
      ST_DIVN: begin
        if (div_done) begin
          ld_qn     = 1'b1;
          div_start = 1'b1;
          state_d   = ST_DIVD;
        end
      end
      ST_DIVD: begin
        r_num_d = wrap(n_neg_q, qn_q);
        r_den_d = wrap(p2_neg_q, div_quot);
        if (div_done) begin
          ld_res  = 1'b1;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          ld_out  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output valid
  always_comb begin
    m_valid_d = m_valid_q;
    if (ld_out) m_valid_d = 1'b1;
    else if (m_axis_tready) m_valid_d = 1'b0;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q <= s_axis_tuser;
      ln_q  <= s_axis_tdata[W-1:0];
      ld_q  <= s_axis_tdata[2*W-1:W];
      rn_q  <= s_axis_tdata[3*W-1:2*W];
      rd_q  <= s_axis_tdata[4*W-1:3*W];
    end
    if (ld_p0) begin
      p0_mag_q <= prod;
      p0_neg_q <= prod_neg;
    end
    if (ld_p1) begin
      p1_mag_q <= prod;
      p1_neg_q <= prod_neg;
    end
    if (ld_p2) begin
      p2_mag_q <= prod;
      p2_neg_q <= prod_neg;
    end
    if (ld_n) begin
      n_mag_q <= n_mag_d;
      n_neg_q <= n_neg_d;
    end
    if (ld_qn) qn_q <= div_quot;
    if (ld_res) begin
      r_num_q <= r_num_d;
      r_den_q <= r_den_d;
      r_cmp_q <= r_cmp_d;
      r_dz_q  <= r_dz_d;
    end
    if (ld_out) begin
      o_num_q <= r_num_q;
      o_den_q <= r_den_q;
      o_cmp_q <= r_cmp_q;
      o_dz_q  <= r_dz_q;
    end
  end

  // Gcd unit and shared divider unit
  rau_gcd #(
    .WIDTH (MW)
  ) u_gcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (gcd_start),
    .a_i     (n_mag_d),
    .b_i     (d_mag),
    .done_o  (gcd_done),
    .g_o     (gcd_g)
  );

  rau_div #(
    .WIDTH (MW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (gcd_g),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OutW'({o_cmp_q, o_den_q, o_num_q});
  assign m_axis_tuser  = o_dz_q;

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && o_dz_q) |-> (o_num_q == '0 && o_den_q == '0 && !o_cmp_q))
    else $error("error word carries a non-zero result");
  a_div_by_g: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> (gcd_g != '0))
    else $error("divider started with a zero gcd");
  a_reduce_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_GCD) |-> (p2_mag_q != '0))
    else $error("gcd run on a zero denominator");
  a_out_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && m_valid_q && !m_axis_tready) |=> (state_q == ST_OUT))
    else $error("pending result dropped while output stalled");

endmodule
